// ===== design/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define VPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising edge, reset included
`define VPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/vpa_pkg.sv =====
// shared types, codes and defaults of the partition allocator
package vpa_pkg;

   localparam int MAX_BLOCKS_DEF  = 64;
   localparam int TOTAL_UNITS_DEF = 8192;

   // fixed port field widths
   localparam int ADDR_W  = 13;
   localparam int SIZE_W  = 13;
   localparam int BCNT_W  = 7;
   localparam int UCNT_W  = 14;
   localparam int OPCNT_W = 32;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;
   localparam logic FIT_BEST   = 1'b0;
   localparam logic FIT_FIRST  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_FETCH_NEXT,
      S_WAIT_NEXT,
      S_MERGE_WR,
      S_SHIFT_DN,
      S_SHIFT_UP,
      S_WR_HI,
      S_WR_LO,
      S_DONE
   } seq_state_type;

   // one result word as it goes to the output stage
   typedef struct packed {
      status_type             status;
      logic [ADDR_W-1:0]      block_address;
      logic [BCNT_W-1:0]      free_blocks;
      logic [BCNT_W-1:0]      used_blocks;
      logic [UCNT_W-1:0]      free_units;
      logic [UCNT_W-1:0]      used_units;
      logic [OPCNT_W-1:0]     operation_count;
   } rsp_word_type;

endpackage

// ===== design/vpa_ram.sv =====
// generic simple dual port ram with registered read
module vpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/vpa_rsp_reg.sv =====
// output register stage of the result channel
module vpa_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  vpa_pkg::rsp_word_type word,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vpa_pkg::rsp_word_type rsp_word
);
   import vpa_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   // slot is free when empty or its word leaves this cycle
   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload holds while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== design/vpa_seq.sv =====
// sequencer: table scan, shifts and counters around the block table ram
module vpa_seq #(
   parameter int MAX_BLOCKS  = vpa_pkg::MAX_BLOCKS_DEF,
   parameter int TOTAL_UNITS = vpa_pkg::TOTAL_UNITS_DEF,
   parameter int EW          = 2 * $clog2(TOTAL_UNITS + 1) + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fit_mode,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [vpa_pkg::SIZE_W-1:0]     req_alloc_size,
   input  logic [vpa_pkg::ADDR_W-1:0]     req_free_address,
   input  logic                           out_can_load,
   output logic                           out_load,
   output vpa_pkg::rsp_word_type          out_word,
   output logic                           ram_wr_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]  ram_wr_addr,
   output logic [EW-1:0]                  ram_wr_data,
   output logic                           ram_rd_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]  ram_rd_addr,
   input  logic [EW-1:0]                  ram_rd_data
);
   import vpa_pkg::*;

   localparam int IW   = $clog2(MAX_BLOCKS);
   localparam int CW   = $clog2(MAX_BLOCKS + 1);
   localparam int SZW  = $clog2(TOTAL_UNITS + 1);
   localparam int CMPW = (SZW > SIZE_W) ? SZW : SIZE_W;
   localparam int FREE_BIT = EW - 1;

   seq_state_type     state_ff, state_in;
   logic              func_ff, func_in;
   logic [SIZE_W-1:0] rq_size_ff, rq_size_in;
   logic [ADDR_W-1:0] rq_addr_ff, rq_addr_in;
   logic [CW-1:0]     scan_ptr_ff, scan_ptr_in;
   logic              rvld_ff, rvld_in;
   logic [CW-1:0]     ridx_ff, ridx_in;
   logic              found_ff, found_in;
   logic [CW-1:0]     pick_ff, pick_in;
   logic [EW-1:0]     pick_ent_ff, pick_ent_in;
   logic [EW-1:0]     prev_ent_ff, prev_ent_in;
   logic [EW-1:0]     next_ent_ff, next_ent_in;
   logic              mp_ff, mp_in;
   logic              mn_ff, mn_in;
   logic [CW-1:0]     sh_ptr_ff, sh_ptr_in;
   logic              sh_vld_ff, sh_vld_in;
   logic [CW-1:0]     sh_dst_ff, sh_dst_in;
   logic [1:0]        dist_ff, dist_in;
   logic [CW-1:0]     ecount_ff, ecount_in;
   logic [CW-1:0]     fb_ff, fb_in;
   logic [CW-1:0]     ub_ff, ub_in;
   logic [SZW-1:0]    fu_ff, fu_in;
   logic [SZW-1:0]    uu_ff, uu_in;
   logic [OPCNT_W-1:0] op_ff, op_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] baddr_ff, baddr_in;

   // entry fields
   logic              rd_free;
   logic [SZW-1:0]    rd_size, rd_start;
   logic [SZW-1:0]    pk_size, pk_start, pv_size, pv_start, nx_size;
   logic [SZW-1:0]    rq_sz;
   logic              fits, match, issue;
   logic [CW-1:0]     pick_nx;

   assign rd_free  = ram_rd_data[FREE_BIT];
   assign rd_size  = ram_rd_data[2*SZW-1:SZW];
   assign rd_start = ram_rd_data[SZW-1:0];
   assign pk_size  = pick_ent_ff[2*SZW-1:SZW];
   assign pk_start = pick_ent_ff[SZW-1:0];
   assign pv_size  = prev_ent_ff[2*SZW-1:SZW];
   assign pv_start = prev_ent_ff[SZW-1:0];
   assign nx_size  = next_ent_ff[2*SZW-1:SZW];
   assign rq_sz    = SZW'(rq_size_ff);
   assign pick_nx  = pick_ff + CW'(1);

   assign fits  = rd_free && (CMPW'(rd_size) > CMPW'(rq_size_ff));
   assign match = !rd_free && (CMPW'(rd_start) == CMPW'(rq_addr_ff));

   // result word from the counters
   always_comb begin
      out_word.status          = status_ff;
      out_word.block_address   = baddr_ff;
      out_word.free_blocks     = BCNT_W'(fb_ff);
      out_word.used_blocks     = BCNT_W'(ub_ff);
      out_word.free_units      = UCNT_W'(fu_ff);
      out_word.used_units      = UCNT_W'(uu_ff);
      out_word.operation_count = op_ff;
   end

   // next state and ram control
   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      rq_size_in  = rq_size_ff;
      rq_addr_in  = rq_addr_ff;
      scan_ptr_in = scan_ptr_ff;
      rvld_in     = 1'b0;
      ridx_in     = ridx_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      pick_ent_in = pick_ent_ff;
      prev_ent_in = prev_ent_ff;
      next_ent_in = next_ent_ff;
      mp_in       = mp_ff;
      mn_in       = mn_ff;
      sh_ptr_in   = sh_ptr_ff;
      sh_vld_in   = 1'b0;
      sh_dst_in   = sh_dst_ff;
      dist_in     = dist_ff;
      ecount_in   = ecount_ff;
      fb_in       = fb_ff;
      ub_in       = ub_ff;
      fu_in       = fu_ff;
      uu_in       = uu_ff;
      op_in       = op_ff;
      status_in   = status_ff;
      baddr_in    = baddr_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      out_load    = 1'b0;
      issue       = 1'b0;
      req_stall   = (state_ff != S_IDLE);

      unique case (state_ff)
         // lay down the single free block
         S_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {1'b1, SZW'(TOTAL_UNITS), SZW'(0)};
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in     = req_func;
               rq_size_in  = req_alloc_size;
               rq_addr_in  = req_free_address;
               scan_ptr_in = '0;
               found_in    = 1'b0;
               prev_ent_in = '0;
               baddr_in    = '0;
               if (req_func == FUNC_ALLOC && req_alloc_size == '0) begin
                  status_in = ST_NO_FIT;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         // walk the table, one read issued per cycle
         S_SCAN: begin
            issue = (scan_ptr_ff < ecount_ff);
            if (issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_ptr_ff[IW-1:0];
               scan_ptr_in = scan_ptr_ff + CW'(1);
            end
            rvld_in = issue;
            ridx_in = scan_ptr_ff;
            if (func_ff == FUNC_ALLOC) begin
               if (rvld_ff && fits &&
                   (!found_ff || (fit_mode == FIT_BEST && rd_size < pk_size))) begin
                  found_in    = 1'b1;
                  pick_in     = ridx_ff;
                  pick_ent_in = ram_rd_data;
               end
               if (!issue && !rvld_ff) begin
                  if (!found_ff) begin
                     status_in = ST_NO_FIT;
                     state_in  = S_DONE;
                  end else if (ecount_ff >= CW'(MAX_BLOCKS)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     sh_ptr_in = ecount_ff - CW'(1);
                     state_in  = S_SHIFT_UP;
                  end
               end
            end else begin
               if (rvld_ff && match) begin
                  pick_in     = ridx_ff;
                  pick_ent_in = ram_rd_data;
                  mp_in       = (ridx_ff != '0) && prev_ent_ff[FREE_BIT];
                  state_in    = S_FETCH_NEXT;
               end else begin
                  if (rvld_ff) begin
                     prev_ent_in = ram_rd_data;
                  end
                  if (!issue && !rvld_ff) begin
                     status_in = ST_NOT_FOUND;
                     op_in     = op_ff + OPCNT_W'(1);
                     state_in  = S_DONE;
                  end
               end
            end
         end
         S_FETCH_NEXT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pick_nx[IW-1:0];
            state_in    = S_WAIT_NEXT;
         end
         S_WAIT_NEXT: begin
            next_ent_in = ram_rd_data;
            mn_in       = (pick_nx < ecount_ff) && rd_free;
            state_in    = S_MERGE_WR;
         end
         // write the freed or merged entry, then close the gap after a merge
         S_MERGE_WR: begin
            ram_wr_en = 1'b1;
            ub_in     = ub_ff - CW'(1);
            fu_in     = fu_ff + pk_size;
            uu_in     = uu_ff - pk_size;
            op_in     = op_ff + OPCNT_W'(1);
            status_in = ST_OK;
            if (mp_ff) begin
               ram_wr_addr = IW'(pick_ff - CW'(1));
               ram_wr_data = {1'b1, pv_size + pk_size + (mn_ff ? nx_size : SZW'(0)),
                              pv_start};
            end else begin
               ram_wr_addr = pick_ff[IW-1:0];
               ram_wr_data = {1'b1, pk_size + (mn_ff ? nx_size : SZW'(0)), pk_start};
            end
            if (mp_ff && mn_ff) begin
               fb_in = fb_ff - CW'(1);
            end else if (!mp_ff && !mn_ff) begin
               fb_in = fb_ff + CW'(1);
            end
            dist_in   = (mp_ff && mn_ff) ? 2'd2 : 2'd1;
            sh_ptr_in = mn_ff ? pick_ff + CW'(2) : pick_nx;
            state_in  = (mp_ff || mn_ff) ? S_SHIFT_DN : S_DONE;
         end
         // move entries down, read one ahead of the write
         S_SHIFT_DN: begin
            if (sh_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = sh_dst_ff[IW-1:0];
               ram_wr_data = ram_rd_data;
            end
            issue = (sh_ptr_ff < ecount_ff);
            if (issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = sh_ptr_ff[IW-1:0];
               sh_dst_in   = sh_ptr_ff - CW'(dist_ff);
               sh_ptr_in   = sh_ptr_ff + CW'(1);
            end
            sh_vld_in = issue;
            if (!issue && !sh_vld_ff) begin
               ecount_in = ecount_ff - CW'(dist_ff);
               state_in  = S_DONE;
            end
         end
         // move entries up to open a slot after the pick
         S_SHIFT_UP: begin
            if (sh_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = sh_dst_ff[IW-1:0];
               ram_wr_data = ram_rd_data;
            end
            issue = (sh_ptr_ff > pick_ff);
            if (issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = sh_ptr_ff[IW-1:0];
               sh_dst_in   = sh_ptr_ff + CW'(1);
               sh_ptr_in   = sh_ptr_ff - CW'(1);
            end
            sh_vld_in = issue;
            if (!issue && !sh_vld_ff) begin
               state_in = S_WR_HI;
            end
         end
         // free remainder after the carved block
         S_WR_HI: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pick_nx[IW-1:0];
            ram_wr_data = {1'b1, pk_size - rq_sz, pk_start + rq_sz};
            state_in    = S_WR_LO;
         end
         S_WR_LO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pick_ff[IW-1:0];
            ram_wr_data = {1'b0, rq_sz, pk_start};
            ecount_in   = ecount_ff + CW'(1);
            ub_in       = ub_ff + CW'(1);
            fu_in       = fu_ff - rq_sz;
            uu_in       = uu_ff + rq_sz;
            op_in       = op_ff + OPCNT_W'(1);
            status_in   = ST_OK;
            baddr_in    = ADDR_W'(pk_start);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_can_load) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         rvld_ff   <= 1'b0;
         sh_vld_ff <= 1'b0;
         ecount_ff <= CW'(1);
         fb_ff     <= CW'(1);
         ub_ff     <= '0;
         fu_ff     <= SZW'(TOTAL_UNITS);
         uu_ff     <= '0;
         op_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         rvld_ff   <= rvld_in;
         sh_vld_ff <= sh_vld_in;
         ecount_ff <= ecount_in;
         fb_ff     <= fb_in;
         ub_ff     <= ub_in;
         fu_ff     <= fu_in;
         uu_ff     <= uu_in;
         op_ff     <= op_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      rq_size_ff  <= rq_size_in;
      rq_addr_ff  <= rq_addr_in;
      scan_ptr_ff <= scan_ptr_in;
      ridx_ff     <= ridx_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      pick_ent_ff <= pick_ent_in;
      prev_ent_ff <= prev_ent_in;
      next_ent_ff <= next_ent_in;
      mp_ff       <= mp_in;
      mn_ff       <= mn_in;
      sh_ptr_ff   <= sh_ptr_in;
      sh_dst_ff   <= sh_dst_in;
      dist_ff     <= dist_in;
      status_ff   <= status_in;
      baddr_ff    <= baddr_in;
   end

endmodule

// ===== design/variable_partition_allocator_top.sv =====
// Each item runs one table scan (one ram read a cycle) and, when entries move, one pass of
// entry moves (one entry a cycle); an allocate of size zero goes straight to the result.
// Throughput: one item at a time; the next word is taken the cycle after the result loads.
// Reset: synchronous, active high; after reset the S_INIT state writes the initial free
// block into the table ram, with req_stall high during it.
module variable_partition_allocator_top #(
   parameter int MAX_BLOCKS  = vpa_pkg::MAX_BLOCKS_DEF,
   parameter int TOTAL_UNITS = vpa_pkg::TOTAL_UNITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [vpa_pkg::SIZE_W-1:0]   req_alloc_size,
   input  logic [vpa_pkg::ADDR_W-1:0]   req_free_address,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [vpa_pkg::ADDR_W-1:0]   rsp_block_address,
   output logic [vpa_pkg::BCNT_W-1:0]   rsp_free_blocks,
   output logic [vpa_pkg::BCNT_W-1:0]   rsp_used_blocks,
   output logic [vpa_pkg::UCNT_W-1:0]   rsp_free_units,
   output logic [vpa_pkg::UCNT_W-1:0]   rsp_used_units,
   output logic [vpa_pkg::OPCNT_W-1:0]  rsp_operation_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_fit_mode
);
   import vpa_pkg::*;

   localparam int IW  = $clog2(MAX_BLOCKS);
   localparam int SZW = $clog2(TOTAL_UNITS + 1);
   localparam int EW  = 2 * SZW + 1;

   logic          fit_mode_ff;
   logic          ram_wr_en, ram_rd_en;
   logic [IW-1:0] ram_wr_addr, ram_rd_addr;
   logic [EW-1:0] ram_wr_data, ram_rd_data;
   logic          out_load, out_can_load;
   rsp_word_type  seq_word, rsp_word;

   // fit mode register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= FIT_BEST;
      end else if (csr_valid && csr_ready) begin
         fit_mode_ff <= csr_fit_mode;
      end
   end

   vpa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   vpa_seq #(.MAX_BLOCKS(MAX_BLOCKS), .TOTAL_UNITS(TOTAL_UNITS), .EW(EW)) u_seq (
      .clock            (clock),
      .reset            (reset),
      .fit_mode         (fit_mode_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_alloc_size   (req_alloc_size),
      .req_free_address (req_free_address),
      .out_can_load     (out_can_load),
      .out_load         (out_load),
      .out_word         (seq_word),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data)
   );

   vpa_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .word      (seq_word),
      .can_load  (out_can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // result word onto the ports
   assign rsp_status          = rsp_word.status;
   assign rsp_block_address   = rsp_word.block_address;
   assign rsp_free_blocks     = rsp_word.free_blocks;
   assign rsp_used_blocks     = rsp_word.used_blocks;
   assign rsp_free_units      = rsp_word.free_units;
   assign rsp_used_units      = rsp_word.used_units;
   assign rsp_operation_count = rsp_word.operation_count;

endmodule

// ===== design/vpa_checker.sv =====
// port level checks of the partition allocator, bound to the top level
`include "assert_macros.svh"

module vpa_checker #(
   parameter int TOTAL_UNITS = vpa_pkg::TOTAL_UNITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic [vpa_pkg::ADDR_W-1:0]   rsp_block_address,
   input logic [vpa_pkg::UCNT_W-1:0]   rsp_free_units,
   input logic [vpa_pkg::UCNT_W-1:0]   rsp_used_units,
   input logic [vpa_pkg::OPCNT_W-1:0]  rsp_operation_count
);
   import vpa_pkg::*;

   // a stalled result word holds
   `VPA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_operation_count), "stalled word changed")

   // free and allocated units of a valid result word cover the whole space
   `VPA_ASSERT(a_units_sum, clock, reset, rsp_valid |-> UCNT_W'(rsp_free_units + rsp_used_units) == UCNT_W'(TOTAL_UNITS), "unit counters do not add up")

   // only a successful allocate carries an address
   `VPA_ASSERT(a_addr_zero, clock, reset, rsp_valid && rsp_status != ST_OK |-> rsp_block_address == '0, "address on a failed item")

   // table setup after reset blocks input
   `VPA_ASSERT_ALWAYS(a_init_stall, clock, !reset && $past(reset) |-> req_stall, "input taken during table setup")

endmodule

bind variable_partition_allocator_top vpa_checker #(.TOTAL_UNITS(TOTAL_UNITS)) u_vpa_checker (.*);
